[hw/rtl/ase_pkg.sv]
// Shared types, constants and codes for the arc signature elite archive.
`timescale 1ns / 1ps

package ase_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int DEF_ARCHIVE_DEPTH = 16;
    localparam int DEF_NODE_BITS     = 12;

    // Fixed field widths.
    localparam int N_BITS    = 12;
    localparam int CAP_BITS  = 5;
    localparam int COST_BITS = 48;
    localparam int ID_BITS   = 16;
    localparam int SIG_BITS  = 64;
    localparam int SLOT_BITS = 4;
    localparam int OCC_BITS  = 5;
    localparam int MUL_BITS  = 32;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AIRCRAFT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ARCHIVE_CAPACITY = 2'd1;

    localparam logic [N_BITS-1:0]   RESET_AIRCRAFT_COUNT   = 12'd1;
    localparam logic [CAP_BITS-1:0] RESET_ARCHIVE_CAPACITY = 5'd16;

    // Mixer constants.
    localparam logic [SIG_BITS-1:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [SIG_BITS-1:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
    localparam logic [SIG_BITS-1:0] MIX_MUL_B  = 64'h94D049BB133111EB;
    localparam int MIX_SHIFT_A   = 30;
    localparam int MIX_SHIFT_B   = 27;
    localparam int MIX_SHIFT_FIN = 31;

    typedef enum logic [1:0] {
        OUT_APPENDED   = 2'd0,
        OUT_REPLACED   = 2'd1,
        OUT_DUPLICATE  = 2'd2,
        OUT_NOT_BETTER = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SEED,
        OP_MUL_LO,
        OP_MUL_X1,
        OP_MUL_X2,
        OP_FOLD,
        OP_SCAN
    } op_t;

    typedef struct packed {
        logic load_in;
        op_t  op;
        logic mix_sel;
        logic decide;
    } dp_cmd_t;

    typedef struct packed {
        logic last_item;
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

[hw/rtl/arc_signature_elite_archive_top.sv]
// Top level of the arc signature elite archive.
// Each aircraft request runs in steps: one to accept, one seed step, six steps of the
// shared 32x32 multiplier for the two 64-bit mixer products, and one fold into the signature.
// A last item then adds a walk through the archive over the one read port, and then a
// decision that loads the result register once the output is free.
// Reset sets aircraft_count to 1, archive_capacity to 16 and empties the archive.
`timescale 1ns / 1ps

module arc_signature_elite_archive_top #(
    parameter int ARCHIVE_DEPTH = ase_pkg::DEF_ARCHIVE_DEPTH,
    parameter int NODE_BITS     = ase_pkg::DEF_NODE_BITS,
    localparam int S_TDATA_W    = ((NODE_BITS + ase_pkg::COST_BITS + ase_pkg::ID_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W    = ((ase_pkg::SLOT_BITS + ase_pkg::ID_BITS + ase_pkg::SIG_BITS
                                    + ase_pkg::OCC_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // From bit 0: aircraft, cost, solution_id, zero fill.
    input  logic [S_TDATA_W-1:0]                s_tdata,
    // runway_start.
    input  logic                                s_tuser,
    // last_item.
    input  logic                                s_tlast,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // From bit 0: slot, evicted_id, signature_out, occupancy, zero fill.
    output logic [M_TDATA_W-1:0]                m_tdata,
    // outcome.
    output logic [1:0]                          m_tuser,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ase_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ase_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import ase_pkg::*;

    localparam int M_USED = SLOT_BITS + ID_BITS + SIG_BITS + OCC_BITS;

    dp_cmd_t              cmd;
    dp_status_t           status;
    outcome_t             outcome;
    logic [SLOT_BITS-1:0] slot;
    logic [ID_BITS-1:0]   evicted_id;
    logic [SIG_BITS-1:0]  signature_out;
    logic [OCC_BITS-1:0]  occupancy;

    // Configuration writes are always taken; the user, not the block, ensures it is idle.
    assign cfg_ready = 1'b1;

    // The controller steps through the mixer, the archive walk and the decision.
    ase_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // The datapath holds the signature registers, the shared multiplier, the archive
    // memory and the output register that decouples the result from new requests.
    ase_datapath #(
        .ARCHIVE_DEPTH (ARCHIVE_DEPTH),
        .NODE_BITS     (NODE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .runway_start  (s_tuser),
        .aircraft      (s_tdata[NODE_BITS-1:0]),
        .last_item     (s_tlast),
        .cost          (s_tdata[NODE_BITS+COST_BITS-1:NODE_BITS]),
        .solution_id   (s_tdata[NODE_BITS+COST_BITS+ID_BITS-1:NODE_BITS+COST_BITS]),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .outcome       (outcome),
        .slot          (slot),
        .evicted_id    (evicted_id),
        .signature_out (signature_out),
        .occupancy     (occupancy)
    );

    assign m_tdata = {{(M_TDATA_W - M_USED){1'b0}}, occupancy, signature_out, evicted_id, slot};
    assign m_tuser = outcome;

`ifndef SYNTHESIS
    // A decision is only made while the output register can take the result.
    a_decide_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |-> status.out_free)
        else $error("decision issued while the result register is busy");

    // Every decision leaves a result waiting on the output.
    a_decide_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |=> m_tvalid)
        else $error("decision did not produce a result");

    // An accepted request keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after a request was accepted");
`endif

endmodule

[hw/rtl/ase_ctrl.sv]
// Sequencing state machine for the arc signature elite archive.
`timescale 1ns / 1ps

module ase_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output ase_pkg::dp_cmd_t    cmd,
    input  ase_pkg::dp_status_t status
);
    import ase_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_M1_LO,
        ST_M1_X1,
        ST_M1_X2,
        ST_M2_LO,
        ST_M2_X1,
        ST_M2_X2,
        ST_FOLD,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    assign s_tready = ready_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd.load_in = 1'b0;
        cmd.op      = OP_NONE;
        cmd.mix_sel = 1'b0;
        cmd.decide  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load_in = s_tvalid && ready_reg;
                if (s_tvalid && ready_reg)
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                cmd.op     = OP_SEED;
                state_next = ST_M1_LO;
            end
            ST_M1_LO:
            begin
                cmd.op     = OP_MUL_LO;
                state_next = ST_M1_X1;
            end
            ST_M1_X1:
            begin
                cmd.op     = OP_MUL_X1;
                state_next = ST_M1_X2;
            end
            ST_M1_X2:
            begin
                cmd.op     = OP_MUL_X2;
                state_next = ST_M2_LO;
            end
            ST_M2_LO:
            begin
                cmd.op      = OP_MUL_LO;
                cmd.mix_sel = 1'b1;
                state_next  = ST_M2_X1;
            end
            ST_M2_X1:
            begin
                cmd.op      = OP_MUL_X1;
                cmd.mix_sel = 1'b1;
                state_next  = ST_M2_X2;
            end
            ST_M2_X2:
            begin
                cmd.op      = OP_MUL_X2;
                cmd.mix_sel = 1'b1;
                state_next  = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.op     = OP_FOLD;
                state_next = status.last_item ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (status.scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

[hw/rtl/ase_datapath.sv]
// Signature mixer, archive memory, search and result register.
`timescale 1ns / 1ps

module ase_datapath #(
    parameter int ARCHIVE_DEPTH = ase_pkg::DEF_ARCHIVE_DEPTH,
    parameter int NODE_BITS     = ase_pkg::DEF_NODE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ase_pkg::dp_cmd_t                    cmd,
    output ase_pkg::dp_status_t                 status,
    input  logic                                runway_start,
    input  logic [NODE_BITS-1:0]                aircraft,
    input  logic                                last_item,
    input  logic [ase_pkg::COST_BITS-1:0]       cost,
    input  logic [ase_pkg::ID_BITS-1:0]         solution_id,
    input  logic                                cfg_write,
    input  logic [ase_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ase_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic                                res_valid,
    input  logic                                res_ready,
    output ase_pkg::outcome_t                   outcome,
    output logic [ase_pkg::SLOT_BITS-1:0]       slot,
    output logic [ase_pkg::ID_BITS-1:0]         evicted_id,
    output logic [ase_pkg::SIG_BITS-1:0]        signature_out,
    output logic [ase_pkg::OCC_BITS-1:0]        occupancy
);
    import ase_pkg::*;

    localparam int AW = (ARCHIVE_DEPTH > 1) ? $clog2(ARCHIVE_DEPTH) : 1;
    localparam int CW = $clog2(ARCHIVE_DEPTH + 1);
    localparam int WW = 8;

    // Configuration.
    logic [N_BITS-1:0]   n_reg;
    logic [CAP_BITS-1:0] cap_reg;

    // Current item.
    logic                 start_reg;
    logic [NODE_BITS-1:0] node_reg;
    logic                 last_reg;
    logic [COST_BITS-1:0] cost_reg;
    logic [ID_BITS-1:0]   id_reg;

    // Signature state.
    logic [NODE_BITS-1:0] prev_reg;
    logic [NODE_BITS-1:0] prev_next;
    logic [SIG_BITS-1:0]  run_sig_reg;
    logic [SIG_BITS-1:0]  run_sig_next;
    logic [SIG_BITS-1:0]  sig_reg;
    logic [SIG_BITS-1:0]  h_reg;
    logic [SIG_BITS-1:0]  h_next;
    logic [SIG_BITS-1:0]  acc_reg;
    logic [SIG_BITS-1:0]  acc_next;

    // Shared 32x32 multiplier.
    logic [MUL_BITS-1:0]   mul_a;
    logic [MUL_BITS-1:0]   mul_b;
    logic [2*MUL_BITS-1:0] mul_p;

    logic [NODE_BITS-1:0] n_node;
    logic [NODE_BITS-1:0] prev_eff;
    logic [N_BITS:0]      n_plus;
    logic [SIG_BITS-1:0]  mix_x;
    logic [SIG_BITS-1:0]  mix_c;
    logic [SIG_BITS-1:0]  fold_v;
    logic [SIG_BITS-1:0]  sig_sum;

    // Archive memory.
    logic [SIG_BITS-1:0]  mem_sig  [ARCHIVE_DEPTH];
    logic [COST_BITS-1:0] mem_cost [ARCHIVE_DEPTH];
    logic [ID_BITS-1:0]   mem_id   [ARCHIVE_DEPTH];
    logic [SIG_BITS-1:0]  rd_sig_reg;
    logic [COST_BITS-1:0] rd_cost_reg;
    logic [ID_BITS-1:0]   rd_id_reg;
    logic                 rd_en;
    logic                 mem_we;
    logic [AW-1:0]        wr_addr;

    // Search state.
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CW-1:0]        scan_idx_reg;
    logic                 scan_more;
    logic                 rd_pend_reg;
    logic [CW-1:0]        rd_idx_reg;
    logic                 dup_found_reg;
    logic [CW-1:0]        dup_slot_reg;
    logic [CW-1:0]        worst_idx_reg;
    logic [COST_BITS-1:0] worst_cost_reg;
    logic [ID_BITS-1:0]   worst_id_reg;
    logic                 scan_init;
    logic                 dup_hit;
    logic                 worse_hit;

    // Decision.
    logic [WW-1:0]        cap_eff;
    logic                 full;
    outcome_t             dec_outcome;
    logic [CW-1:0]        dec_slot;
    logic [ID_BITS-1:0]   dec_evicted;

    // Result register.
    logic                 res_valid_reg;
    outcome_t             res_outcome_reg;
    logic [SLOT_BITS-1:0] res_slot_reg;
    logic [ID_BITS-1:0]   res_evicted_reg;
    logic [SIG_BITS-1:0]  res_sig_reg;
    logic [OCC_BITS-1:0]  res_occ_reg;

    assign n_node   = NODE_BITS'(n_reg);
    assign prev_eff = start_reg ? n_node : prev_reg;
    assign n_plus   = {1'b0, n_reg} + (N_BITS + 1)'(1);
    assign mix_c    = cmd.mix_sel ? MIX_MUL_B : MIX_MUL_A;
    assign mix_x    = cmd.mix_sel ? (h_reg ^ (h_reg >> MIX_SHIFT_B))
                                  : (h_reg ^ (h_reg >> MIX_SHIFT_A));
    assign fold_v   = h_reg ^ (h_reg >> MIX_SHIFT_FIN);
    assign sig_sum  = run_sig_reg + fold_v;
    assign mul_p    = mul_a * mul_b;

    // Each 64-bit product keeps its low half: lo*lo plus the two cross
    // terms shifted up, one partial product per cycle.
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        h_next   = h_reg;
        acc_next = acc_reg;
        case (cmd.op)
            OP_SEED:
            begin
                mul_a  = MUL_BITS'(prev_eff);
                mul_b  = MUL_BITS'(n_plus);
                h_next = mul_p + SIG_BITS'(node_reg) + MIX_GOLDEN;
            end
            OP_MUL_LO:
            begin
                mul_a    = mix_x[MUL_BITS-1:0];
                mul_b    = mix_c[MUL_BITS-1:0];
                acc_next = mul_p;
            end
            OP_MUL_X1:
            begin
                mul_a    = mix_x[MUL_BITS-1:0];
                mul_b    = mix_c[SIG_BITS-1:MUL_BITS];
                acc_next = acc_reg + {mul_p[MUL_BITS-1:0], {MUL_BITS{1'b0}}};
            end
            OP_MUL_X2:
            begin
                mul_a  = mix_x[SIG_BITS-1:MUL_BITS];
                mul_b  = mix_c[MUL_BITS-1:0];
                h_next = acc_reg + {mul_p[MUL_BITS-1:0], {MUL_BITS{1'b0}}};
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        prev_next    = prev_reg;
        run_sig_next = run_sig_reg;
        if (cmd.op == OP_FOLD)
        begin
            if (last_reg)
            begin
                prev_next    = '0;
                run_sig_next = '0;
            end
            else
            begin
                prev_next    = node_reg;
                run_sig_next = sig_sum;
            end
        end
    end

    assign scan_init = (cmd.op == OP_FOLD) && last_reg;
    assign scan_more = scan_idx_reg < count_reg;
    assign rd_en     = (cmd.op == OP_SCAN) && scan_more;
    assign dup_hit   = rd_pend_reg && !dup_found_reg && (rd_sig_reg == sig_reg);
    assign worse_hit = rd_pend_reg &&
                       ((rd_idx_reg == '0) || (rd_cost_reg > worst_cost_reg));

    // Effective capacity is the register saturated into one..depth.
    always_comb
    begin
        cap_eff = WW'(cap_reg);
        if (cap_eff == '0)
        begin
            cap_eff = WW'(1);
        end
        else if (cap_eff > WW'(ARCHIVE_DEPTH))
        begin
            cap_eff = WW'(ARCHIVE_DEPTH);
        end
    end

    assign full = WW'(count_reg) >= cap_eff;

    always_comb
    begin
        dec_outcome = OUT_NOT_BETTER;
        dec_slot    = '0;
        dec_evicted = '0;
        mem_we      = 1'b0;
        wr_addr     = count_reg[AW-1:0];
        count_next  = count_reg;
        if (dup_found_reg)
        begin
            dec_outcome = OUT_DUPLICATE;
            dec_slot    = dup_slot_reg;
        end
        else if (!full)
        begin
            dec_outcome = OUT_APPENDED;
            dec_slot    = count_reg;
            mem_we      = cmd.decide;
            count_next  = count_reg + CW'(1);
        end
        else if (worst_cost_reg > cost_reg)
        begin
            dec_outcome = OUT_REPLACED;
            dec_slot    = worst_idx_reg;
            dec_evicted = worst_id_reg;
            mem_we      = cmd.decide;
            wr_addr     = worst_idx_reg[AW-1:0];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= RESET_AIRCRAFT_COUNT;
            cap_reg       <= RESET_ARCHIVE_CAPACITY;
            prev_reg      <= '0;
            run_sig_reg   <= '0;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            dup_found_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_AIRCRAFT_COUNT:   n_reg   <= cfg_data[N_BITS-1:0];
                    CFG_ARCHIVE_CAPACITY: cap_reg <= cfg_data[CAP_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            prev_reg    <= prev_next;
            run_sig_reg <= run_sig_next;
            if (scan_init)
            begin
                scan_idx_reg  <= '0;
                rd_pend_reg   <= 1'b0;
                dup_found_reg <= 1'b0;
            end
            else if (cmd.op == OP_SCAN)
            begin
                rd_pend_reg <= scan_more;
                if (scan_more)
                begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                end
                if (dup_hit)
                begin
                    dup_found_reg <= 1'b1;
                end
            end
            if (cmd.decide)
            begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            start_reg <= runway_start;
            node_reg  <= aircraft;
            last_reg  <= last_item;
            cost_reg  <= cost;
            id_reg    <= solution_id;
        end
        h_reg   <= h_next;
        acc_reg <= acc_next;
        if (scan_init)
        begin
            sig_reg <= sig_sum;
        end
        if (rd_en)
        begin
            rd_idx_reg <= scan_idx_reg;
        end
        if (dup_hit)
        begin
            dup_slot_reg <= rd_idx_reg;
        end
        if (worse_hit)
        begin
            worst_idx_reg  <= rd_idx_reg;
            worst_cost_reg <= rd_cost_reg;
            worst_id_reg   <= rd_id_reg;
        end
        if (cmd.decide)
        begin
            res_outcome_reg <= dec_outcome;
            res_slot_reg    <= SLOT_BITS'(dec_slot);
            res_evicted_reg <= dec_evicted;
            res_sig_reg     <= sig_reg;
            res_occ_reg     <= OCC_BITS'(count_next);
        end
    end

    // Archive memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_sig[wr_addr]  <= sig_reg;
            mem_cost[wr_addr] <= cost_reg;
            mem_id[wr_addr]   <= id_reg;
        end
        if (rd_en)
        begin
            rd_sig_reg  <= mem_sig[scan_idx_reg[AW-1:0]];
            rd_cost_reg <= mem_cost[scan_idx_reg[AW-1:0]];
            rd_id_reg   <= mem_id[scan_idx_reg[AW-1:0]];
        end
    end

    assign status.last_item = last_reg;
    assign status.scan_done = !scan_more && !rd_pend_reg;
    assign status.out_free  = !res_valid_reg || res_ready;

    assign res_valid     = res_valid_reg;
    assign outcome       = res_outcome_reg;
    assign slot          = res_slot_reg;
    assign evicted_id    = res_evicted_reg;
    assign signature_out = res_sig_reg;
    assign occupancy     = res_occ_reg;

endmodule
